// ===== rtl/rsd_pkg.sv =====
package rsd_pkg;

  // Largest number of distance samples emitted per reply.
  localparam int MaxSamples  = 2048;
  // Sample counter must be able to hold MaxSamples itself.
  localparam int IdxW        = $clog2(MaxSamples + 1);

  localparam int ValueW      = 24;
  localparam int IndexW      = 11;
  localparam int BitsPerChar = 6;

  localparam logic [7:0] LineFeed = 8'h0a;
  localparam logic [7:0] CharBase = 8'h30;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
    logic       frame_last;
  } rsd_in_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_timestamp;
    logic [IndexW-1:0] sample_index;
  } rsd_out_t;

  // Output buffer status seen by the input side.
  typedef struct packed {
    logic full;
  } rsd_buf_stat_t;

endpackage

// ===== rtl/rsd_parser.sv =====
module rsd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rsd_pkg::rsd_in_t  item_i,
  output logic              emit_o,
  output rsd_pkg::rsd_out_t res_o
);
  import rsd_pkg::*;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhStamp  = 2'd1,
    PhData   = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [ValueW-1:0] acc;
    logic [2:0]        cnt;
    logic [IdxW-1:0]   idx;
    logic              emit;
    rsd_out_t          res;
  } char_step_t;

  // Shift one character into the group and close the group when complete.
  function automatic char_step_t take_char(phase_e ph, logic [ValueW-1:0] acc,
                                           logic [2:0] cnt, logic [IdxW-1:0] idx,
                                           logic [7:0] b);
    char_step_t       r;
    logic [7:0]       diff;
    diff         = b - CharBase;
    r.phase      = ph;
    r.acc        = {acc[ValueW-BitsPerChar-1:0], diff[BitsPerChar-1:0]};
    r.cnt        = cnt + 3'd1;
    r.idx        = idx;
    r.emit       = 1'b0;
    r.res        = '0;
    if (ph == PhStamp && r.cnt >= 3'd4) begin
      r.emit             = 1'b1;
      r.res.value        = r.acc;
      r.res.is_timestamp = 1'b1;
      r.res.sample_index = '0;
      r.phase            = PhData;
      r.acc              = '0;
      r.cnt              = '0;
    end else if (ph == PhData && r.cnt >= 3'd3) begin
      if (idx < IdxW'(MaxSamples)) begin
        r.emit             = 1'b1;
        r.res.value        = r.acc;
        r.res.is_timestamp = 1'b0;
        r.res.sample_index = IndexW'(idx);
        r.idx              = idx + 1'b1;
      end
      r.acc = '0;
      r.cnt = '0;
    end
    return r;
  endfunction

  phase_e            phase_q, phase_d, ph_e;
  logic [1:0]        hb_q, hb_d, hb_e;
  logic [7:0]        held_q, held_d, held_e;
  logic              hv_q, hv_d, hv_e;
  logic              prev_q, prev_d, prev_e;
  logic [ValueW-1:0] acc_q, acc_d, acc_e;
  logic [2:0]        cnt_q, cnt_d, cnt_e;
  logic [IdxW-1:0]   idx_q, idx_d, idx_e;
  char_step_t        t1, t2;
  logic              is_lf;

  assign is_lf = (item_i.rx_byte == LineFeed);

  always_comb begin
    // A first byte restarts from the reset state before it is parsed.
    if (item_i.frame_first) begin
      ph_e = PhHeader; hb_e = '0; held_e = '0; hv_e = 1'b0;
      prev_e = 1'b0; acc_e = '0; cnt_e = '0; idx_e = '0;
    end else begin
      ph_e = phase_q; hb_e = hb_q; held_e = held_q; hv_e = hv_q;
      prev_e = prev_q; acc_e = acc_q; cnt_e = cnt_q; idx_e = idx_q;
    end

    phase_d = ph_e; hb_d = hb_e; held_d = held_e; hv_d = hv_e;
    prev_d = prev_e; acc_d = acc_e; cnt_d = cnt_e; idx_d = idx_e;
    emit_o  = 1'b0;
    res_o   = '0;
    t1      = '0;
    t2      = '0;

    if (ph_e == PhDone) begin
      // drop everything until the next first byte
    end else if (ph_e == PhHeader) begin
      if (is_lf) begin
        if (hb_e < 2'd3) hb_d = hb_e + 2'd1;
        if (hb_d >= 2'd2) phase_d = PhStamp;
        prev_d = 1'b1;
      end else begin
        prev_d = 1'b0;
      end
      if (item_i.frame_last) phase_d = PhDone;
    end else begin
      if (is_lf) begin
        // held byte was the line's check character
        hv_d = 1'b0;
        if (prev_e) phase_d = PhDone;
        prev_d = 1'b1;
      end else begin
        if (hv_e) begin
          t1      = take_char(ph_e, acc_e, cnt_e, idx_e, held_e);
          phase_d = t1.phase;
          acc_d   = t1.acc;
          cnt_d   = t1.cnt;
          idx_d   = t1.idx;
          emit_o  = t1.emit;
          res_o   = t1.res;
        end
        held_d = item_i.rx_byte;
        hv_d   = 1'b1;
        prev_d = 1'b0;
      end

      if (item_i.frame_last && phase_d != PhDone) begin
        if (hv_d) begin
          // flush the last byte as data; a partial group is lost
          t2    = take_char(phase_d, acc_d, cnt_d, idx_d, held_d);
          acc_d = t2.acc;
          cnt_d = t2.cnt;
          idx_d = t2.idx;
          if (!emit_o) begin
            emit_o = t2.emit;
            res_o  = t2.res;
          end
        end
        hv_d    = 1'b0;
        phase_d = PhDone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      hb_q    <= '0;
      held_q  <= '0;
      hv_q    <= 1'b0;
      prev_q  <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hb_q    <= hb_d;
      held_q  <= held_d;
      hv_q    <= hv_d;
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !item_i.frame_first) |-> !emit_o)
    else $error("result produced after end of frame");

  a_stamp_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && emit_o && res_o.is_timestamp) |=>
      (phase_q == PhData || phase_q == PhDone))
    else $error("parser not in data phase after timestamp");

endmodule

// ===== rtl/rsd_out_buf.sv =====
module rsd_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rsd_pkg::rsd_out_t      item_i,
  output rsd_pkg::rsd_buf_stat_t stat_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rsd_pkg::rsd_out_t      out_item_o
);
  import rsd_pkg::*;

  rsd_out_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o  = (cnt_q != 2'd0);
  assign out_item_o   = slot_q[rd_q];
  assign pop          = out_valid_o && !out_stall_i;
  assign stat_o.full  = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("push into full output buffer");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("output buffer count wrong after pop");

endmodule

// ===== rtl/range_scan_reply_decoder.sv =====
// A result is offered once parsed; the parser state updates in a single pass.
// Throughput: one byte per cycle while the output buffer has room.
// A two-entry output buffer keeps bytes flowing while a result waits.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase
// and empties both the input register and the output buffer.
module range_scan_reply_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rsd_pkg::rsd_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsd_pkg::rsd_out_t out_item_o
);
  import rsd_pkg::*;

  logic          in_valid_q, in_valid_d;
  rsd_in_t       in_item_q;
  logic          accept, fire, emit;
  rsd_out_t      res;
  rsd_buf_stat_t buf_stat;

  // Parse the held item only when the output buffer has room.
  assign fire       = in_valid_q && !buf_stat.full;
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
  end

  rsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .emit_o (emit),
    .res_o  (res)
  );

  rsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && emit),
    .item_i      (res),
    .stat_o      (buf_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/tb_range_scan_reply_decoder.sv =====
`timescale 1ns / 1ps

module tb_range_scan_reply_decoder;
  import rsd_pkg::*;

  typedef enum logic [1:0] {
    SCAN_HEADER,
    SCAN_STAMP,
    SCAN_DATA,
    SCAN_DONE
  } scan_phase_e;

  typedef struct packed {
    rsd_in_t  item;
    logic     typed;
    rsd_out_t want;
  } step_row_t;

  localparam logic [36:0] Predicted = '0;

  // Short replies: timestamp and samples at the character extremes, check
  // characters, end at an empty line, end at a marked last byte, last byte
  // inside the header.
  localparam int NumSteps = 27;
  localparam step_row_t Steps [NumSteps] = '{
    {8'h56, 1'b1, 1'b0, Predicted},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h30, 1'b0, 1'b0, Predicted},
    {8'h30, 1'b0, 1'b0, Predicted},
    {8'h30, 1'b0, 1'b0, Predicted},
    {8'h6f, 1'b0, 1'b0, Predicted},
    {8'hff, 1'b0, 1'b0, 1'b1, 24'h00003f, 1'b1, 11'd0},
    {8'h00, 1'b0, 1'b0, Predicted},
    {8'h2f, 1'b0, 1'b0, Predicted},
    {8'h58, 1'b0, 1'b0, 1'b1, 24'h00f43f, 1'b0, 11'd0},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h6f, 1'b0, 1'b0, Predicted},
    {8'h6f, 1'b0, 1'b0, Predicted},
    {8'h6f, 1'b0, 1'b0, Predicted},
    {8'h6f, 1'b0, 1'b0, 1'b1, 24'h03ffff, 1'b0, 11'd1},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h0a, 1'b1, 1'b0, Predicted},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h0d, 1'b0, 1'b0, Predicted},
    {8'h31, 1'b0, 1'b0, Predicted},
    {8'h0a, 1'b0, 1'b0, Predicted},
    {8'h32, 1'b0, 1'b0, Predicted},
    {8'h33, 1'b0, 1'b0, Predicted},
    {8'h34, 1'b0, 1'b1, Predicted},
    {8'h78, 1'b1, 1'b1, Predicted}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  rsd_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rsd_out_t out_item_o;

  range_scan_reply_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Parser copy
  scan_phase_e      scan_ph;
  logic [1:0]       lf_count;
  logic [7:0]       held_char;
  logic             held_live;
  logic             last_was_lf;
  logic [23:0]      group_acc;
  logic [2:0]       group_len;
  logic [IdxW-1:0]  sample_next;

  rsd_out_t fresh_q[$];
  rsd_out_t decoded_q[$];
  int       mismatches = 0;
  int       parsed_items = 0;
  int       calm_in = 0;
  int       calm_out = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_parser();
    scan_ph     = SCAN_HEADER;
    lf_count    = '0;
    held_char   = '0;
    held_live   = 1'b0;
    last_was_lf = 1'b0;
    group_acc   = '0;
    group_len   = '0;
    sample_next = '0;
  endfunction

  function automatic void add_char(logic [7:0] b);
    logic [7:0] diff;
    rsd_out_t   r;
    diff      = b - CharBase;
    group_acc = {group_acc[ValueW-BitsPerChar-1:0], diff[BitsPerChar-1:0]};
    group_len = group_len + 3'd1;
    if (scan_ph == SCAN_STAMP && group_len >= 3'd4) begin
      r.value        = group_acc;
      r.is_timestamp = 1'b1;
      r.sample_index = '0;
      fresh_q.push_back(r);
      scan_ph   = SCAN_DATA;
      group_acc = '0;
      group_len = '0;
    end else if (scan_ph == SCAN_DATA && group_len >= 3'd3) begin
      // past the sample limit the group is still decoded but dropped
      if (sample_next < MaxSamples) begin
        r.value        = group_acc;
        r.is_timestamp = 1'b0;
        r.sample_index = sample_next[IndexW-1:0];
        fresh_q.push_back(r);
        sample_next++;
      end
      group_acc = '0;
      group_len = '0;
    end
  endfunction

  function automatic void decode_byte(rsd_in_t it);
    if (it.frame_first) clear_parser();
    if (scan_ph == SCAN_DONE) return;
    if (scan_ph == SCAN_HEADER) begin
      if (it.rx_byte == LineFeed) begin
        if (lf_count < 2'd3) lf_count++;
        if (lf_count >= 2'd2) scan_ph = SCAN_STAMP;
        last_was_lf = 1'b1;
      end else begin
        last_was_lf = 1'b0;
      end
      if (it.frame_last) scan_ph = SCAN_DONE;
      return;
    end
    if (it.rx_byte == LineFeed) begin
      // held byte was the line's check character
      held_live = 1'b0;
      if (last_was_lf) scan_ph = SCAN_DONE;
      last_was_lf = 1'b1;
    end else begin
      if (held_live) add_char(held_char);
      held_char   = it.rx_byte;
      held_live   = 1'b1;
      last_was_lf = 1'b0;
    end
    if (it.frame_last && scan_ph != SCAN_DONE) begin
      if (held_live) add_char(held_char);
      held_live = 1'b0;
      scan_ph   = SCAN_DONE;
    end
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic rsd_in_t mk(logic [7:0] b, logic f, logic l);
    rsd_in_t it;
    it.rx_byte     = b;
    it.frame_first = f;
    it.frame_last  = l;
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) != 0) return 8'($urandom_range(48, 111));
    do c = 8'($urandom); while (c == LineFeed);
    return c;
  endfunction

  task automatic send(rsd_in_t it, logic typed, rsd_out_t want);
    int gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (scan_ph != SCAN_DONE || it.frame_first) parsed_items++;
    fresh_q.delete();
    decode_byte(it);
    if (typed) decoded_q.push_back(want);
    else foreach (fresh_q[i]) decoded_q.push_back(fresh_q[i]);
    @(negedge clk_i);
  endtask

  // Well-formed reply with random content; a broken one is cut short.
  task automatic play_reply(int groups, int line_max, bit broken);
    logic [7:0] txt[$];
    int         left;
    int         len;
    int         cut;
    bit         mark_last;
    repeat (2) begin
      repeat ($urandom_range(0, 4)) txt.push_back(pick_char());
      txt.push_back(LineFeed);
    end
    left = 4 + 3 * groups;
    while (left > 0) begin
      len = $urandom_range(1, line_max);
      if (len > left) len = left;
      repeat (len) txt.push_back(pick_char());
      left -= len;
      if ($urandom_range(0, 15) != 0) txt.push_back(pick_char());
      txt.push_back(LineFeed);
    end
    mark_last = $urandom_range(0, 1);
    if (!mark_last) txt.push_back(LineFeed);
    else if ($urandom_range(0, 2) == 0) void'(txt.pop_back());
    if (broken) begin
      cut = $urandom_range(1, txt.size());
      while (txt.size() > cut) void'(txt.pop_back());
      if ($urandom_range(0, 1) == 0) txt[$urandom_range(0, txt.size() - 1)] = LineFeed;
    end
    foreach (txt[i]) send(mk(txt[i], i == 0, mark_last && i == txt.size() - 1), 1'b0, '0);
  endtask

  task automatic play_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 12)) begin
      b = ($urandom_range(0, 3) == 0) ? LineFeed : 8'($urandom);
      send(mk(b, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0), 1'b0, '0);
    end
  endtask

  task automatic check_result(rsd_out_t got);
    rsd_out_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing outstanding", got));
      return;
    end
    want = decoded_q.pop_front();
    if (got.value !== want.value)
      flag_mismatch($sformatf("value %h, want %h", got.value, want.value));
    if (got.is_timestamp !== want.is_timestamp)
      flag_mismatch($sformatf("is_timestamp %b, want %b", got.is_timestamp,
                              want.is_timestamp));
    if (got.sample_index !== want.sample_index)
      flag_mismatch($sformatf("sample_index %0d, want %0d", got.sample_index,
                              want.sample_index));
  endtask

  // Result side
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_wait(calm_out);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_item_o);
      @(negedge clk_i);
    end
  end

  // Byte side
  initial begin
    int start;
    int kind;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    clear_parser();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumSteps; i++) send(Steps[i].item, Steps[i].typed, Steps[i].want);

    // one reply long enough to run past the sample limit
    play_reply(MaxSamples + 12, 64, 1'b0);

    start = parsed_items;
    while (parsed_items - start < 900) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) play_reply($urandom_range(0, 12), $urandom_range(1, 16), 1'b0);
      else if (kind == 7) play_reply($urandom_range(0, 12), $urandom_range(1, 16), 1'b1);
      else play_noise();
    end
    in_valid_i = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (decoded_q.size() != 0)
      flag_mismatch($sformatf("%0d results never came", decoded_q.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
